// ===== design/imu_pkt_pkg.sv =====
// Package with the frame constants, parser phase type and result struct of the IMU angle parser.
`timescale 1ns / 1ps
`default_nettype none

package imu_pkt_pkg;

  // Frame layout constants.
  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_BYTE = 8'h53;
  localparam int unsigned FRAME_LEN = 11;
  localparam int unsigned SUM_LEN   = 10;
  localparam int unsigned ANGLE_FIRST = 2;
  localparam int unsigned ANGLE_BYTES = 6;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ANGLE_W = 16;

  localparam logic [CNT_W-1:0] CNT_SUM_LEN     = CNT_W'(SUM_LEN);
  localparam logic [CNT_W-1:0] CNT_ANGLE_FIRST = CNT_W'(ANGLE_FIRST);
  localparam logic [CNT_W-1:0] CNT_ANGLE_END   = CNT_W'(ANGLE_FIRST + ANGLE_BYTES);

  // Checksum status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Result of one frame, plus the flag that says the current byte closes a frame.
  typedef struct packed {
    logic                      ends_frame;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic                      frame_status;
  } res_t;

endpackage

`default_nettype wire

// ===== design/imu_pkt_fsm.sv =====
// Frame parser: header hunt, byte count, running checksum and angle byte storage.
`timescale 1ns / 1ps
`default_nettype none

module imu_pkt_fsm (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            byte_vld,
  input  wire logic [imu_pkt_pkg::BYTE_W-1:0]  byte_i,
  output imu_pkt_pkg::res_t                    res
);

  imu_pkt_pkg::phase_t                    phase_r, phase_nxt;
  logic [imu_pkt_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [imu_pkt_pkg::BYTE_W-1:0]         sum_r, sum_nxt;
  logic [imu_pkt_pkg::BYTE_W-1:0]         angle_r [imu_pkt_pkg::ANGLE_BYTES];
  logic                                   ends_frame;
  logic                                   sum_ok;
  logic                                   angle_we;
  logic [2:0]                             angle_off;

  // The checksum byte is reached once ten bytes are held.
  assign ends_frame = (phase_r == imu_pkt_pkg::PH_DATA) && (cnt_r >= imu_pkt_pkg::CNT_SUM_LEN);
  assign sum_ok     = (sum_r == byte_i);

  // Next phase, count and running sum.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    if (byte_vld) begin
      case (phase_r)
        imu_pkt_pkg::PH_TYPE: begin
          if (byte_i == imu_pkt_pkg::TYPE_BYTE) begin
            sum_nxt   = sum_r + byte_i;
            cnt_nxt   = imu_pkt_pkg::CNT_ANGLE_FIRST;
            phase_nxt = imu_pkt_pkg::PH_DATA;
          end else begin
            phase_nxt = imu_pkt_pkg::PH_HUNT;
          end
        end
        imu_pkt_pkg::PH_DATA: begin
          if (ends_frame) begin
            phase_nxt = imu_pkt_pkg::PH_HUNT;
            cnt_nxt   = '0;
            sum_nxt   = '0;
          end else begin
            sum_nxt = sum_r + byte_i;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        default: begin
          if (byte_i == imu_pkt_pkg::HDR_BYTE) begin
            sum_nxt   = byte_i;
            cnt_nxt   = imu_pkt_pkg::CNT_W'(1);
            phase_nxt = imu_pkt_pkg::PH_TYPE;
          end else begin
            phase_nxt = imu_pkt_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= imu_pkt_pkg::PH_HUNT;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Frame bytes two through seven land in the angle store.
  assign angle_off = 3'(cnt_r - imu_pkt_pkg::CNT_ANGLE_FIRST);
  assign angle_we  = byte_vld && (phase_r == imu_pkt_pkg::PH_DATA)
                     && (cnt_r >= imu_pkt_pkg::CNT_ANGLE_FIRST)
                     && (cnt_r < imu_pkt_pkg::CNT_ANGLE_END);

  always_ff @(posedge clk) begin
    if (angle_we) begin
      angle_r[angle_off] <= byte_i;
    end
  end

  // Result fields; angles read as zero on a checksum mismatch.
  always_comb begin
    res.ends_frame   = ends_frame;
    res.frame_status = sum_ok ? imu_pkt_pkg::STATUS_OK : imu_pkt_pkg::STATUS_BAD;
    if (sum_ok) begin
      res.roll_angle  = {angle_r[1], angle_r[0]};
      res.pitch_angle = {angle_r[3], angle_r[2]};
      res.yaw_angle   = {angle_r[5], angle_r[4]};
    end else begin
      res.roll_angle  = '0;
      res.pitch_angle = '0;
      res.yaw_angle   = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/imu_angle_packet_parser.sv =====
// Top level: input byte register, frame parser and result register with stream handshakes.
// A frame's result enters the result register as its checksum byte leaves the input register.
// Throughput: one byte per cycle; a result waiting in the output register holds the
// input register only when the next registered byte is itself a checksum byte.
// Reset (rst_n, synchronous, active low) empties both registers and returns the
// parser to header hunt with count and running sum cleared.
`timescale 1ns / 1ps
`default_nettype none

module imu_angle_packet_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] roll_angle, [31:16] pitch_angle, [47:32] yaw_angle
  output logic [0:0]       out_tuser   // [0] frame_status
);

  logic                                  in_valid_r, in_valid_nxt;
  logic [imu_pkt_pkg::BYTE_W-1:0]        in_byte_r;
  logic                                  out_valid_r, out_valid_nxt;
  imu_pkt_pkg::res_t                     out_res_r;
  imu_pkt_pkg::res_t                     res;
  logic                                  stall;
  logic                                  fire;
  logic                                  res_vld;

  // A checksum byte waits while the result register is full and not taken.
  assign stall     = in_valid_r && res.ends_frame && out_valid_r && !out_tready;
  assign fire      = in_valid_r && !stall;
  assign res_vld   = fire && res.ends_frame;
  assign in_tready = !in_valid_r || !stall;

  // Input item register.
  assign in_valid_nxt = (in_tvalid && in_tready) || (in_valid_r && stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Frame parser.
  imu_pkt_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (fire),
    .byte_i   (in_byte_r),
    .res      (res)
  );

  // Result register.
  assign out_valid_nxt = res_vld || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  // Output packing.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.yaw_angle, out_res_r.pitch_angle, out_res_r.roll_angle};
  assign out_tuser  = out_res_r.frame_status;

endmodule

`default_nettype wire
